// ----- sv/mbe_pkg.sv -----
// ----------------------------------------------------------------------------
// mbe_pkg
// Shared types, constants and a helper function for the escape-time block.
// ----------------------------------------------------------------------------
`default_nettype none

package mbe_pkg;

    // Fixed-point format and frame bounds.
    localparam int FRAC_BITS  = 24;
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;

    // Field and register widths.
    localparam int COORD_W  = 11;
    localparam int CFG_W    = 28;
    localparam int LIMIT_W  = 31;
    localparam int ITER_W   = 8;
    localparam int FRAME_W  = 12;
    localparam int DATA_W   = 32;
    localparam int PROD_W   = 64;
    localparam int CIDX_W   = 3;

    // Register reset values.
    localparam logic [CFG_W-1:0]   RST_RE_ORIGIN = 28'hE000000;
    localparam logic [CFG_W-1:0]   RST_IM_ORIGIN = 28'hE000000;
    localparam logic [CFG_W-1:0]   RST_RE_STEP   = 28'h0008000;
    localparam logic [CFG_W-1:0]   RST_IM_STEP   = 28'h0008000;
    localparam logic [LIMIT_W-1:0] RST_ESC_LIMIT = 31'h14000000;
    localparam logic [ITER_W-1:0]  RST_ITER_LIM  = 8'd255;
    localparam logic [FRAME_W-1:0] RST_FRAME_W   = 12'd2048;
    localparam logic [FRAME_W-1:0] RST_FRAME_H   = 12'd2048;

    // Configuration register indexes.
    typedef enum logic [CIDX_W-1:0] {
        CFG_RE_ORIGIN  = 3'd0,
        CFG_IM_ORIGIN  = 3'd1,
        CFG_RE_STEP    = 3'd2,
        CFG_IM_STEP    = 3'd3,
        CFG_ESC_LIMIT  = 3'd4,
        CFG_ITER_LIMIT = 3'd5,
        CFG_FRAME_W    = 3'd6,
        CFG_FRAME_H    = 3'd7
    } t_cfg_idx;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CRE,
        ST_CIM,
        ST_INIT,
        ST_PROD,
        ST_SQRE,
        ST_SQIM,
        ST_TEST
    } t_state;

    // Operand selection for the shared multiplier.
    typedef enum logic [2:0] {
        MUL_COL,
        MUL_ROW,
        MUL_ZZ,
        MUL_TR,
        MUL_TI
    } t_mul_sel;

    // Control bundle from the sequencer to the datapath.
    typedef struct packed {
        logic              load_in;
        t_mul_sel          mul_sel;
        logic              ld_cre;
        logic              ld_cim;
        logic              init_z;
        logic              ld_tr;
        logic              ld_ti;
        logic              ld_sqr;
        logic              test;
        logic              finish;
        logic [ITER_W-1:0] count;
    } t_ctrl;

    // Saturate a 64-bit signed value to signed 32 bits.
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [DATA_W-1:0] res;
        if (v[PROD_W-1:DATA_W-1] == {(PROD_W-DATA_W+1){v[PROD_W-1]}}) begin
            res = v[DATA_W-1:0];
        end else if (v[PROD_W-1]) begin
            res = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(DATA_W-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- sv/mbe_mul.sv -----
// ----------------------------------------------------------------------------
// mbe_mul
// Shared signed 32 x 32 multiplier with a registered 64-bit product.
// ----------------------------------------------------------------------------
`default_nettype none

module mbe_mul (
    input  wire logic                                  i_clk,
    input  wire logic signed [mbe_pkg::DATA_W-1:0]     i_a,
    input  wire logic signed [mbe_pkg::DATA_W-1:0]     i_b,
    output logic signed [mbe_pkg::PROD_W-1:0]          o_prod
);

    logic signed [mbe_pkg::PROD_W-1:0] r_prod;

    // The product is registered, ready in the cycle after the operands.
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

// ----- sv/mbe_ctrl.sv -----
// ----------------------------------------------------------------------------
// mbe_ctrl
// Sequencer: steps the shared multiplier through the set-up products and
// the three products of each iteration, and counts iterations.
// ----------------------------------------------------------------------------
`default_nettype none

module mbe_ctrl (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic [mbe_pkg::ITER_W-1:0]        i_iter_limit,
    input  wire logic                              i_escape,
    output logic                                   o_busy,
    output mbe_pkg::t_ctrl                         o_ctrl
);

    mbe_pkg::t_state              r_state, n_state;
    logic [mbe_pkg::ITER_W-1:0]   r_iter, n_iter;
    logic [mbe_pkg::ITER_W-1:0]   w_iter_inc;

    assign w_iter_inc = r_iter + 1'b1;

    // State and iteration counter registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mbe_pkg::ST_IDLE;
            r_iter  <= '0;
        end else begin
            r_state <= n_state;
            r_iter  <= n_iter;
        end
    end

    // Next state and control decode.
    always_comb begin
        n_state        = r_state;
        n_iter         = r_iter;
        o_busy         = 1'b1;
        o_ctrl         = '0;
        o_ctrl.mul_sel = mbe_pkg::MUL_ZZ;
        case (r_state)
            mbe_pkg::ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_ctrl.load_in = 1'b1;
                    n_iter         = '0;
                    n_state        = mbe_pkg::ST_CRE;
                end
            end
            mbe_pkg::ST_CRE: begin
                o_ctrl.mul_sel = mbe_pkg::MUL_COL;
                n_state        = mbe_pkg::ST_CIM;
            end
            mbe_pkg::ST_CIM: begin
                o_ctrl.mul_sel = mbe_pkg::MUL_ROW;
                o_ctrl.ld_cre  = 1'b1;
                n_state        = mbe_pkg::ST_INIT;
            end
            mbe_pkg::ST_INIT: begin
                o_ctrl.ld_cim = 1'b1;
                o_ctrl.init_z = 1'b1;
                // A zero limit tries no iteration at all.
                if (i_iter_limit == '0) begin
                    o_ctrl.finish = 1'b1;
                    o_ctrl.count  = '0;
                    n_state       = mbe_pkg::ST_IDLE;
                end else begin
                    n_state = mbe_pkg::ST_PROD;
                end
            end
            mbe_pkg::ST_PROD: begin
                o_ctrl.mul_sel = mbe_pkg::MUL_ZZ;
                o_ctrl.ld_tr   = 1'b1;
                n_state        = mbe_pkg::ST_SQRE;
            end
            mbe_pkg::ST_SQRE: begin
                o_ctrl.mul_sel = mbe_pkg::MUL_TR;
                o_ctrl.ld_ti   = 1'b1;
                n_state        = mbe_pkg::ST_SQIM;
            end
            mbe_pkg::ST_SQIM: begin
                o_ctrl.mul_sel = mbe_pkg::MUL_TI;
                o_ctrl.ld_sqr  = 1'b1;
                n_state        = mbe_pkg::ST_TEST;
            end
            mbe_pkg::ST_TEST: begin
                o_ctrl.test = 1'b1;
                if (i_escape) begin
                    o_ctrl.finish = 1'b1;
                    o_ctrl.count  = r_iter;
                    n_state       = mbe_pkg::ST_IDLE;
                end else begin
                    n_iter = w_iter_inc;
                    if (w_iter_inc == i_iter_limit) begin
                        o_ctrl.finish = 1'b1;
                        o_ctrl.count  = w_iter_inc;
                        n_state       = mbe_pkg::ST_IDLE;
                    end else begin
                        n_state = mbe_pkg::ST_PROD;
                    end
                end
            end
            default: begin
                n_state = mbe_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/mandelbrot_escape_time.sv -----
// ----------------------------------------------------------------------------
// mandelbrot_escape_time
// Escape-time count for one pixel in signed Q8.24 fixed point.
// ----------------------------------------------------------------------------
// One pixel is taken when start is high and busy is low. The block forms c
// from the origin and step registers, iterates z = z^2 + c and returns the
// escape count together with a last-pixel flag, shown for one cycle with
// o_valid; the receiver must take it then, as it cannot be held. A pixel's
// run time grows with its iteration count and is set by the single shared
// 32 x 32 multiplier: after the two set-up products for c, each iteration
// needs three products (zr*zi, re^2, im^2) and an escape test step. Busy is
// low again in the cycle of the strobe, so the next pixel may be started
// then. The user must write the configuration registers only while busy is
// low; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module mandelbrot_escape_time (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic [mbe_pkg::COORD_W-1:0]          i_column,
    input  wire logic [mbe_pkg::COORD_W-1:0]          i_row,
    input  wire logic                                 i_cfg_we,
    input  wire logic [mbe_pkg::CIDX_W-1:0]           i_cfg_index,
    input  wire logic [mbe_pkg::LIMIT_W-1:0]          i_cfg_data,
    output logic                                      o_valid,
    output logic [mbe_pkg::ITER_W-1:0]                o_escape_count,
    output logic                                      o_frame_done
);

    localparam int PROD_W = mbe_pkg::PROD_W;

    // Configuration registers.
    logic [mbe_pkg::CFG_W-1:0]    r_re_origin, r_im_origin, r_re_step, r_im_step;
    logic [mbe_pkg::LIMIT_W-1:0]  r_escape_limit;
    logic [mbe_pkg::ITER_W-1:0]   r_iteration_limit;
    logic [mbe_pkg::FRAME_W-1:0]  r_frame_width, r_frame_height;

    // Datapath registers.
    logic [mbe_pkg::COORD_W-1:0]          r_col, r_row;
    logic signed [mbe_pkg::DATA_W-1:0]    r_cre, r_cim, r_zr, r_zi, r_tr, r_ti;
    logic signed [mbe_pkg::PROD_W-1:0]    r_sq_r, r_diff;

    // Result registers.
    logic                         r_valid;
    logic [mbe_pkg::ITER_W-1:0]   r_count;
    logic                         r_frame_done;

    mbe_pkg::t_ctrl                       w_ctrl;
    logic signed [mbe_pkg::DATA_W-1:0]    w_mul_a, w_mul_b;
    logic signed [mbe_pkg::PROD_W-1:0]    w_prod;
    logic [mbe_pkg::PROD_W-1:0]           w_mag, w_bound;
    logic                                 w_escape;
    logic [31:0]                          w_lim_w, w_lim_h;
    logic                                 w_last;

    // Configuration write port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_re_origin       <= mbe_pkg::RST_RE_ORIGIN;
            r_im_origin       <= mbe_pkg::RST_IM_ORIGIN;
            r_re_step         <= mbe_pkg::RST_RE_STEP;
            r_im_step         <= mbe_pkg::RST_IM_STEP;
            r_escape_limit    <= mbe_pkg::RST_ESC_LIMIT;
            r_iteration_limit <= mbe_pkg::RST_ITER_LIM;
            r_frame_width     <= mbe_pkg::RST_FRAME_W;
            r_frame_height    <= mbe_pkg::RST_FRAME_H;
        end else if (i_cfg_we) begin
            case (mbe_pkg::t_cfg_idx'(i_cfg_index))
                mbe_pkg::CFG_RE_ORIGIN:  r_re_origin       <= i_cfg_data[mbe_pkg::CFG_W-1:0];
                mbe_pkg::CFG_IM_ORIGIN:  r_im_origin       <= i_cfg_data[mbe_pkg::CFG_W-1:0];
                mbe_pkg::CFG_RE_STEP:    r_re_step         <= i_cfg_data[mbe_pkg::CFG_W-1:0];
                mbe_pkg::CFG_IM_STEP:    r_im_step         <= i_cfg_data[mbe_pkg::CFG_W-1:0];
                mbe_pkg::CFG_ESC_LIMIT:  r_escape_limit    <= i_cfg_data;
                mbe_pkg::CFG_ITER_LIMIT: r_iteration_limit <= i_cfg_data[mbe_pkg::ITER_W-1:0];
                mbe_pkg::CFG_FRAME_W:    r_frame_width     <= i_cfg_data[mbe_pkg::FRAME_W-1:0];
                mbe_pkg::CFG_FRAME_H:    r_frame_height    <= i_cfg_data[mbe_pkg::FRAME_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Sequencer.
    mbe_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_iter_limit (r_iteration_limit),
        .i_escape     (w_escape),
        .o_busy       (busy),
        .o_ctrl       (w_ctrl)
    );

    // Operand selection for the shared multiplier.
    always_comb begin
        case (w_ctrl.mul_sel)
            mbe_pkg::MUL_COL: begin
                w_mul_a = $signed({{(mbe_pkg::DATA_W-mbe_pkg::COORD_W){1'b0}}, r_col});
                w_mul_b = $signed({{(mbe_pkg::DATA_W-mbe_pkg::CFG_W){r_re_step[mbe_pkg::CFG_W-1]}},
                                   r_re_step});
            end
            mbe_pkg::MUL_ROW: begin
                w_mul_a = $signed({{(mbe_pkg::DATA_W-mbe_pkg::COORD_W){1'b0}}, r_row});
                w_mul_b = $signed({{(mbe_pkg::DATA_W-mbe_pkg::CFG_W){r_im_step[mbe_pkg::CFG_W-1]}},
                                   r_im_step});
            end
            mbe_pkg::MUL_TR: begin
                w_mul_a = r_tr;
                w_mul_b = r_tr;
            end
            mbe_pkg::MUL_TI: begin
                w_mul_a = r_ti;
                w_mul_b = r_ti;
            end
            default: begin
                w_mul_a = r_zr;
                w_mul_b = r_zi;
            end
        endcase
    end

    mbe_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    // Escape test: exact squared magnitude against the bound.
    assign w_mag    = $unsigned(r_sq_r) + $unsigned(w_prod);
    assign w_bound  = {{(mbe_pkg::PROD_W-mbe_pkg::LIMIT_W){1'b0}}, r_escape_limit}
                      << mbe_pkg::FRAC_BITS;
    assign w_escape = w_mag > w_bound;

    // Datapath: c, the new z parts and the stored squares.
    always_ff @(posedge i_clk) begin
        if (w_ctrl.load_in) begin
            r_col <= i_column;
            r_row <= i_row;
        end
        if (w_ctrl.ld_cre) begin
            r_cre <= mbe_pkg::sat32(w_prod + $signed({{(mbe_pkg::PROD_W-mbe_pkg::CFG_W)
                                                      {r_re_origin[mbe_pkg::CFG_W-1]}},
                                                      r_re_origin}));
        end
        if (w_ctrl.ld_cim) begin
            r_cim <= mbe_pkg::sat32(w_prod + $signed({{(mbe_pkg::PROD_W-mbe_pkg::CFG_W)
                                                      {r_im_origin[mbe_pkg::CFG_W-1]}},
                                                      r_im_origin}));
        end
        if (w_ctrl.init_z) begin
            r_zr   <= '0;
            r_zi   <= '0;
            r_diff <= '0;
        end
        if (w_ctrl.ld_tr) begin
            r_tr <= mbe_pkg::sat32((r_diff >>> mbe_pkg::FRAC_BITS) + PROD_W'(r_cre));
        end
        if (w_ctrl.ld_ti) begin
            r_ti <= mbe_pkg::sat32((w_prod >>> (mbe_pkg::FRAC_BITS - 1)) + PROD_W'(r_cim));
        end
        if (w_ctrl.ld_sqr) begin
            r_sq_r <= w_prod;
        end
        // The squares of the new z feed the next real part.
        if (w_ctrl.test) begin
            r_diff <= r_sq_r - w_prod;
            r_zr   <= r_tr;
            r_zi   <= r_ti;
        end
    end

    // Last-pixel test with the frame size clamped to its maximum.
    assign w_lim_w = (32'(r_frame_width) > 32'(mbe_pkg::MAX_WIDTH)) ?
                     32'(mbe_pkg::MAX_WIDTH) : 32'(r_frame_width);
    assign w_lim_h = (32'(r_frame_height) > 32'(mbe_pkg::MAX_HEIGHT)) ?
                     32'(mbe_pkg::MAX_HEIGHT) : 32'(r_frame_height);
    assign w_last  = (w_lim_w != '0) && (w_lim_h != '0) &&
                     (32'(r_col) == w_lim_w - 32'd1) && (32'(r_row) == w_lim_h - 32'd1);

    // Result register: one-cycle strobe per pixel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_ctrl.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.finish) begin
            r_count      <= w_ctrl.count;
            r_frame_done <= w_last;
        end
    end

    assign o_valid        = r_valid;
    assign o_escape_count = r_count;
    assign o_frame_done   = r_frame_done;

`ifndef SYNTHESIS
    // A result is a single-cycle strobe.
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe lasted more than one cycle");

    // An accepted pixel keeps the block busy in the following cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after a pixel transfer");

    // A result appears only once the sequencer has returned to idle.
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while still busy");

    // The count never exceeds the iteration limit.
    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_escape_count <= r_iteration_limit))
        else $error("escape count above iteration limit");

    // Every finish follows a transfer: no result without a pending pixel.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(busy))
        else $error("result without a pixel in progress");
`endif

endmodule

`default_nettype wire

// ----- verif/mandelbrot_escape_time_tb.sv -----
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_tb
// Self-checking bench for the Mandelbrot escape-time block.
// ----------------------------------------------------------------------------
// Pixels wait in a queue that the stimulus process fills. A driver presents
// them on the start/busy handshake, and a monitor predicts the escape count
// and last-pixel flag of every accepted pixel. It then compares each strobed
// result with the oldest prediction. The run starts with directed pixels: the
// field extremes, a zero iteration limit, a zero escape limit, zero and
// oversized frames, saturating c values and pixels outside the frame. Random
// register settings follow, under changing sender idle rates.
// ----------------------------------------------------------------------------

module mandelbrot_escape_time_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import mbe_pkg::*;

    localparam int      WATCHDOG_LIMIT = 8192;
    localparam int      SETTLE_CYCLES  = 8;
    localparam int      PIXEL_LATENCY  = 1040;
    localparam int      RANDOM_PHASES  = 12;
    localparam int      DEEP_PHASE     = 5;
    localparam longint  S32_MAX        = 64'sd2147483647;
    localparam longint  S32_MIN        = -64'sd2147483648;

    typedef struct {
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
    } t_pixel;

    typedef struct {
        logic [ITER_W-1:0] count;
        logic              frame_done;
    } t_escape_result;

    // Clock, reset and block inputs, all known from time zero.
    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  start          = 1'b0;
    logic [COORD_W-1:0]    i_column       = '0;
    logic [COORD_W-1:0]    i_row          = '0;
    logic                  i_cfg_we       = 1'b0;
    logic [CIDX_W-1:0]     i_cfg_index    = CFG_RE_ORIGIN;
    logic [LIMIT_W-1:0]    i_cfg_data     = '0;
    logic                  busy;
    logic                  o_valid;
    logic [ITER_W-1:0]     o_escape_count;
    logic                  o_frame_done;

    // Shadow copy of the configuration registers.
    logic signed [CFG_W-1:0] cfg_re_origin  = RST_RE_ORIGIN;
    logic signed [CFG_W-1:0] cfg_im_origin  = RST_IM_ORIGIN;
    logic signed [CFG_W-1:0] cfg_re_step    = RST_RE_STEP;
    logic signed [CFG_W-1:0] cfg_im_step    = RST_IM_STEP;
    logic [LIMIT_W-1:0]      cfg_esc_limit  = RST_ESC_LIMIT;
    logic [ITER_W-1:0]       cfg_iter_limit = RST_ITER_LIM;
    logic [FRAME_W-1:0]      cfg_frame_w    = RST_FRAME_W;
    logic [FRAME_W-1:0]      cfg_frame_h    = RST_FRAME_H;

    // Pending pixels and predicted results.
    t_pixel          pixel_queue[$];
    t_escape_result  escape_expected[$];
    t_escape_result  want;

    bit  pixel_taken      = 1'b0;
    int  sender_idle_pct  = 0;
    int  stall_cycles     = 0;
    int  pixels_sent      = 0;
    int  results_seen     = 0;
    int  mismatch_count   = 0;
    int  limit_hits       = 0;
    int  frame_flags      = 0;
    int  settings_used    = 0;

    mandelbrot_escape_time i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_column       (i_column),
        .i_row          (i_row),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_valid        (o_valid),
        .o_escape_count (o_escape_count),
        .o_frame_done   (o_frame_done)
    );

    // 8 ns clock.
    always #4 i_clk = ~i_clk;

    // Saturate to the signed 32-bit range.
    function automatic longint clamp32(input longint v);
        if (v > S32_MAX) begin
            return S32_MAX;
        end
        if (v < S32_MIN) begin
            return S32_MIN;
        end
        return v;
    endfunction

    // Escape count and last-pixel flag for one pixel under the current settings.
    function automatic t_escape_result predict_escape(input logic [COORD_W-1:0] col,
                                                      input logic [COORD_W-1:0] row);
        t_escape_result res;
        longint         c_re;
        longint         c_im;
        longint         z_re;
        longint         z_im;
        longint         t_re;
        longint         t_im;
        logic [63:0]    bound;
        logic [63:0]    mag;
        int             n;
        bit             escaped;
        int             w;
        int             h;
        c_re    = clamp32(longint'(cfg_re_origin) + longint'(col) * longint'(cfg_re_step));
        c_im    = clamp32(longint'(cfg_im_origin) + longint'(row) * longint'(cfg_im_step));
        bound   = 64'(cfg_esc_limit) << FRAC_BITS;
        z_re    = 0;
        z_im    = 0;
        n       = 0;
        escaped = 1'b0;
        while (!escaped && n < int'(cfg_iter_limit)) begin
            t_re = clamp32(((z_re * z_re - z_im * z_im) >>> FRAC_BITS) + c_re);
            t_im = clamp32(((z_re * z_im) >>> (FRAC_BITS - 1)) + c_im);
            mag  = t_re * t_re;
            mag  = mag + 64'(t_im * t_im);
            if (mag > bound) begin
                escaped = 1'b1;
            end else begin
                z_re = t_re;
                z_im = t_im;
                n++;
            end
        end
        w = (int'(cfg_frame_w) > MAX_WIDTH) ? MAX_WIDTH : int'(cfg_frame_w);
        h = (int'(cfg_frame_h) > MAX_HEIGHT) ? MAX_HEIGHT : int'(cfg_frame_h);
        res.count      = ITER_W'(n);
        res.frame_done = (w != 0) && (h != 0) && (int'(col) == w - 1) && (int'(row) == h - 1);
        return res;
    endfunction

    // Driver: presents the head of the pixel queue, holding it until the transfer.
    always @(negedge i_clk) begin
        if (pixel_taken) begin
            void'(pixel_queue.pop_front());
        end
        if (!i_rst_n || pixel_queue.size() == 0) begin
            start <= 1'b0;
        end else begin
            i_column <= pixel_queue[0].column;
            i_row    <= pixel_queue[0].row;
            if (start && !pixel_taken) begin
                start <= 1'b1;
            end else begin
                start <= ($urandom_range(99) >= sender_idle_pct);
            end
        end
    end

    // Report a wrong or unexpected result; only the first few are printed.
    task automatic report_mismatch(input string what, input t_escape_result exp_res);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t: %s at result %0d: count exp %0d got %0d, frame_done exp %0b got %0b",
                     $realtime, what, results_seen, exp_res.count, o_escape_count,
                     exp_res.frame_done, o_frame_done);
        end
    endtask

    // Monitor: checks strobed results, predicts accepted pixels, guards progress.
    always @(posedge i_clk) begin
        pixel_taken = 1'b0;
        if (i_rst_n) begin
            if (o_valid) begin
                results_seen++;
                if (escape_expected.size() == 0) begin
                    want.count      = '0;
                    want.frame_done = 1'b0;
                    report_mismatch("result with no pixel outstanding", want);
                end else begin
                    want = escape_expected.pop_front();
                    if (o_escape_count !== want.count || o_frame_done !== want.frame_done) begin
                        report_mismatch("mismatch", want);
                    end
                end
            end
            if (start && !busy) begin
                want = predict_escape(i_column, i_row);
                escape_expected.push_back(want);
                if (want.count == cfg_iter_limit) begin
                    limit_hits++;
                end
                if (want.frame_done) begin
                    frame_flags++;
                end
                pixels_sent++;
                pixel_taken = 1'b1;
            end
            if (pixel_taken || o_valid || i_cfg_we) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                         $realtime, stall_cycles, escape_expected.size());
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Write one register and mirror it in the shadow copy.
    task automatic write_reg(input t_cfg_idx idx, input logic [LIMIT_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            CFG_RE_ORIGIN:  cfg_re_origin  = val[CFG_W-1:0];
            CFG_IM_ORIGIN:  cfg_im_origin  = val[CFG_W-1:0];
            CFG_RE_STEP:    cfg_re_step    = val[CFG_W-1:0];
            CFG_IM_STEP:    cfg_im_step    = val[CFG_W-1:0];
            CFG_ESC_LIMIT:  cfg_esc_limit  = val;
            CFG_ITER_LIMIT: cfg_iter_limit = val[ITER_W-1:0];
            CFG_FRAME_W:    cfg_frame_w    = val[FRAME_W-1:0];
            CFG_FRAME_H:    cfg_frame_h    = val[FRAME_W-1:0];
            default: ;
        endcase
    endtask

    // Load a complete register set; only called while the block is idle.
    task automatic apply_settings(input int re_o, input int im_o, input int re_s,
                                  input int im_s, input int esc, input int iters,
                                  input int fw, input int fh);
        write_reg(CFG_RE_ORIGIN, LIMIT_W'(re_o));
        write_reg(CFG_IM_ORIGIN, LIMIT_W'(im_o));
        write_reg(CFG_RE_STEP, LIMIT_W'(re_s));
        write_reg(CFG_IM_STEP, LIMIT_W'(im_s));
        write_reg(CFG_ESC_LIMIT, LIMIT_W'(esc));
        write_reg(CFG_ITER_LIMIT, LIMIT_W'(iters));
        write_reg(CFG_FRAME_W, LIMIT_W'(fw));
        write_reg(CFG_FRAME_H, LIMIT_W'(fh));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Hold off until every queued pixel has been transferred and answered.
    task automatic wait_drained();
        while (pixel_queue.size() != 0 || escape_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic push_pixel(input int col, input int row);
        t_pixel px;
        px.column = COORD_W'(col);
        px.row    = COORD_W'(row);
        pixel_queue.push_back(px);
    endtask

    // Random pixels: some on the frame's last pixel, some inside it, the rest anywhere.
    task automatic push_random_pixels(input int count);
        int w;
        int h;
        int pick;
        w = (int'(cfg_frame_w) > MAX_WIDTH) ? MAX_WIDTH : int'(cfg_frame_w);
        h = (int'(cfg_frame_h) > MAX_HEIGHT) ? MAX_HEIGHT : int'(cfg_frame_h);
        repeat (count) begin
            pick = $urandom_range(15);
            if (pick == 0 && w != 0 && h != 0) begin
                push_pixel(w - 1, h - 1);
            end else if (pick < 8 && w != 0 && h != 0) begin
                push_pixel($urandom_range(w - 1), $urandom_range(h - 1));
            end else begin
                push_pixel($urandom_range(2047), $urandom_range(2047));
            end
        end
    endtask

    // Stimulus: directed settings first, then random settings and pixels.
    initial begin
        int re_o;
        int im_o;
        int re_s;
        int im_s;
        int esc;
        int iters;
        int fw;
        int fh;
        int count;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: corners, c = 0 inside the set, and the frame's last pixel.
        push_pixel(0, 0);
        push_pixel(2047, 2047);
        push_pixel(1024, 1024);
        push_pixel(2047, 0);
        push_pixel(0, 2047);
        push_pixel(1023, 1025);
        wait_drained();

        // No iterations at all, and an empty frame that never completes.
        apply_settings(-33554432, -33554432, 32768, 32768, 1 << 30, 0, 0, 0);
        push_pixel(0, 0);
        push_pixel(2047, 2047);
        push_pixel(1024, 1024);
        push_pixel(2047, 0);
        wait_drained();

        // Zero escape bound: only z = 0 survives. The frame is clamped to the maximum.
        apply_settings(0, 0, 1, 0, 0, 255, 4095, 2049);
        push_pixel(2047, 2047);
        push_pixel(0, 0);
        push_pixel(1, 5);
        wait_drained();

        // Register extremes: c saturates, z saturates, single-pixel frame.
        apply_settings(-134217728, 134217727, 134217727, -134217728, 32'h7FFF_FFFF, 3, 1, 1);
        push_pixel(0, 0);
        push_pixel(2047, 2047);
        push_pixel(2047, 0);
        push_pixel(0, 2047);
        push_pixel(1, 1);
        wait_drained();

        // Random settings, each phase paused halfway until all results are in.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p % 4 == 3) begin
                re_o = int'($urandom);
                im_o = int'($urandom);
                re_s = int'($urandom);
                im_s = int'($urandom);
            end else begin
                re_o = -41943040 + int'($urandom_range(50331648));
                im_o = -25165824 + int'($urandom_range(25165824));
                re_s = $urandom_range(24576, 1);
                im_s = $urandom_range(24576, 1);
                if ($urandom_range(3) == 0) begin
                    im_s = -im_s;
                end
            end
            esc   = (p % 3 == 0) ? (1 << 26) : int'($urandom_range(1 << 30, 1));
            iters = (p == DEEP_PHASE) ? 255 : int'($urandom_range(48, 1));
            if (p % 2 == 0) begin
                fw = $urandom_range(64, 1);
                fh = $urandom_range(64, 1);
            end else begin
                fw = $urandom_range(4095);
                fh = $urandom_range(4095);
            end
            count = (p == DEEP_PHASE) ? 60 : 160;
            case (p % 3)
                0:       sender_idle_pct = 0;
                1:       sender_idle_pct = 47;
                default: sender_idle_pct = 29;
            endcase
            apply_settings(re_o, im_o, re_s, im_s, esc, iters, fw, fh);
            push_random_pixels(count / 2);
            wait_drained();
            push_random_pixels(count - count / 2);
            wait_drained();
        end

        // Let any stray strobe show up before judging the run.
        repeat (PIXEL_LATENCY) @(posedge i_clk);
        if (escape_expected.size() != 0) begin
            $display("%0d expected results never arrived", escape_expected.size());
        end
        $display("Run covered %0d pixels under %0d register settings; %0d results checked.",
                 pixels_sent, settings_used + 1, results_seen);
        $display("%0d pixels ran to the iteration limit, %0d marked the end of a frame.",
                 limit_hits, frame_flags);
        if (mismatch_count == 0 && escape_expected.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
